>>> rtl/lrptd_pkg.sv
// lrptd_pkg: shared constants, codes and control/status types of the lr parse engine
// used by lrptd_ctrl, lrptd_dp and lr_parse_table_driver_core; depends on nothing
`default_nettype none
package lrptd_pkg;

	// default sizes
	localparam int DEF_TABLE_WORDS = 1024;
	localparam int DEF_STACK_DEPTH = 256;
	localparam int DEF_STEP_LIMIT  = 64;

	// field widths
	localparam int DATA_W  = 16;
	localparam int ST_W    = 10;
	localparam int LA_W    = 11;
	localparam int KIND_W  = 3;
	localparam int IDX_W   = 18;
	localparam int TSEL_W  = 4;
	localparam int NUM_TABLES = 10;

	// opcodes
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_TOKEN = 2'd2;

	// event kinds
	localparam logic [KIND_W-1:0] EV_SHIFT    = 3'd0;
	localparam logic [KIND_W-1:0] EV_REDUCE   = 3'd1;
	localparam logic [KIND_W-1:0] EV_ACCEPT   = 3'd2;
	localparam logic [KIND_W-1:0] EV_SYNTAX   = 3'd3;
	localparam logic [KIND_W-1:0] EV_OVERFLOW = 3'd4;
	localparam logic [KIND_W-1:0] EV_LIMIT    = 3'd5;

	// table numbers as used by load items
	localparam int TS_TT = 0;
	localparam int TS_LH = 1;
	localparam int TS_RL = 2;
	localparam int TS_DR = 3;
	localparam int TS_DG = 4;
	localparam int TS_SB = 5;
	localparam int TS_RB = 6;
	localparam int TS_GB = 7;
	localparam int TS_PA = 8;
	localparam int TS_PC = 9;

	// source of a pushed state
	localparam logic [1:0] PUSH_PA    = 2'd0;
	localparam logic [1:0] PUSH_DG    = 2'd1;
	localparam logic [1:0] PUSH_FINAL = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic              load;
		logic              start;
		logic              xlat_rd;
		logic              xlat_ld;
		logic              rd_state;
		logic              chk_shift;
		logic              chk_red;
		logic              chk_goto;
		logic              rule_dr;
		logic              rule_pa;
		logic              rd_rule;
		logic              pop;
		logic              st_ld;
		logic              rd_goto;
		logic              push;
		logic [1:0]        push_sel;
		logic              clr_la;
		logic              emit;
		logic [KIND_W-1:0] emit_kind;
		logic              emit_rule;
		logic              flush;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic dr_zero;
		logic la_neg;
		logic la_zero;
		logic xlat_zero;
		logic hit;
		logic full;
		logic st_zero;
		logic lhs_zero;
		logic pend_v;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

>>> rtl/lrptd_ram.sv
// lrptd_ram: generic single write port, single read port ram with registered read
// no package dependency
`default_nettype none
module lrptd_ram #(
	parameter int W     = 16,
	parameter int DEPTH = 1024,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds until next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/lrptd_dp.sv
// lrptd_dp: datapath of the lr parse engine: parse tables, state stack, working registers,
// packed lookup checks and the result holding/output registers; uses lrptd_pkg, lrptd_ram
`default_nettype none
module lrptd_dp #(
	parameter int TABLE_WORDS = lrptd_pkg::DEF_TABLE_WORDS,
	parameter int STACK_DEPTH = lrptd_pkg::DEF_STACK_DEPTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire lrptd_pkg::cmd_t                   cmd,
	output lrptd_pkg::sts_t                        sts,
	input  wire logic                              cfg_we,
	input  wire logic                              cfg_index,
	input  wire logic [lrptd_pkg::ST_W-1:0]        cfg_data,
	input  wire logic [lrptd_pkg::TSEL_W-1:0]      table_select,
	input  wire logic [9:0]                        entry_index,
	input  wire logic signed [lrptd_pkg::DATA_W-1:0] entry_value,
	input  wire logic [9:0]                        entry_token,
	input  wire logic [9:0]                        token_tag,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [lrptd_pkg::KIND_W-1:0]           event_kind,
	output logic [9:0]                             rule_number,
	output logic [lrptd_pkg::ST_W-1:0]             new_state,
	output logic signed [lrptd_pkg::LA_W-1:0]      lookahead_code,
	output logic                                   last_event
);

	localparam int AW  = $clog2(TABLE_WORDS);
	localparam int SPW = $clog2(STACK_DEPTH);
	localparam int NT  = lrptd_pkg::NUM_TABLES;
	localparam int DW  = lrptd_pkg::DATA_W;
	localparam int SW  = lrptd_pkg::ST_W;
	localparam int XW  = lrptd_pkg::IDX_W;
	localparam int LW  = lrptd_pkg::LA_W;
	localparam int KW  = lrptd_pkg::KIND_W;

	// configuration
	logic [SW-1:0] plimit_q, final_q;

	// working registers
	logic [SW-1:0]        st_q;
	logic [SPW-1:0]       sp_q;
	logic signed [LW-1:0] la_q;
	logic signed [DW-1:0] rule_q;
	logic                 pre_q;
	logic [SW-1:0]        key_q;
	logic [NT-1:0]        rg_q;

	// table ports
	logic [DW-1:0]        rdat [NT];
	logic [DW-1:0]        tdat [NT];
	logic signed [XW-1:0] ridx [NT];
	logic [NT-1:0]        rre;
	logic [NT-1:0]        rwe;
	logic [NT-1:0]        rin;

	// packed lookup
	logic                 chk;
	logic signed [DW-1:0] pbase;
	logic [SW-1:0]        pkey;
	logic signed [XW-1:0] pn;
	logic                 pre_d;

	// stack
	logic [SPW-1:0] sp_inc, sp_pop;
	logic [SW-1:0]  push_val;
	logic [SW-1:0]  stk_rdata;
	logic           stk_we;
	logic [SPW-1:0] stk_waddr;
	logic [SW-1:0]  stk_wdata;
	logic signed [DW-1:0] len;
	logic           len_ge;
	logic           load_ok;

	// result holding and output registers
	logic          pend_v_q, out_v_q;
	logic [KW-1:0] pend_kind_q;
	logic [9:0]    pend_rule_q;
	logic [SW-1:0] pend_st_q;
	logic signed [LW-1:0] pend_la_q;
	logic          out_free;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plimit_q <= '0;
			final_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) begin
				plimit_q <= cfg_data;
			end else begin
				final_q <= cfg_data;
			end
		end
	end

	// read index per table
	always_comb begin
		ridx[lrptd_pkg::TS_TT] = XW'({1'b0, token_tag});
		ridx[lrptd_pkg::TS_DR] = XW'({1'b0, st_q});
		ridx[lrptd_pkg::TS_SB] = XW'({1'b0, st_q});
		ridx[lrptd_pkg::TS_RB] = XW'({1'b0, st_q});
		ridx[lrptd_pkg::TS_RL] = XW'(rule_q);
		ridx[lrptd_pkg::TS_LH] = XW'(rule_q);
		ridx[lrptd_pkg::TS_GB] = XW'($signed(tdat[lrptd_pkg::TS_LH]));
		ridx[lrptd_pkg::TS_DG] = XW'($signed(tdat[lrptd_pkg::TS_LH]));
		ridx[lrptd_pkg::TS_PA] = pn;
		ridx[lrptd_pkg::TS_PC] = pn;
		rre = '0;
		rre[lrptd_pkg::TS_TT] = cmd.xlat_rd;
		rre[lrptd_pkg::TS_DR] = cmd.rd_state;
		rre[lrptd_pkg::TS_SB] = cmd.rd_state;
		rre[lrptd_pkg::TS_RB] = cmd.rd_state;
		rre[lrptd_pkg::TS_RL] = cmd.rd_rule;
		rre[lrptd_pkg::TS_LH] = cmd.rd_rule;
		rre[lrptd_pkg::TS_GB] = cmd.rd_goto;
		rre[lrptd_pkg::TS_DG] = cmd.rd_goto;
		rre[lrptd_pkg::TS_PA] = chk;
		rre[lrptd_pkg::TS_PC] = chk;
	end

	assign load_ok = cmd.load && (32'(entry_index) < TABLE_WORDS);

	// table memories, out-of-range reads give zero
	for (genvar i = 0; i < NT; i++) begin : g_tab
		assign rin[i]  = !ridx[i][XW-1] && (ridx[i] < XW'(TABLE_WORDS));
		assign rwe[i]  = load_ok && (table_select == lrptd_pkg::TSEL_W'(i));
		assign tdat[i] = rg_q[i] ? rdat[i] : '0;

		lrptd_ram #(.W(DW), .DEPTH(TABLE_WORDS)) u_tab (
			.clk  (clk),
			.we   (rwe[i]),
			.waddr(AW'(entry_index)),
			.wdata(entry_value),
			.re   (rre[i]),
			.raddr(ridx[i][AW-1:0]),
			.rdata(rdat[i])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rg_q[i] <= 1'b0;
			end else if (rre[i]) begin
				rg_q[i] <= rin[i];
			end
		end
	end

	// packed lookup: base plus key, bounded by packed_limit
	always_comb begin
		chk   = cmd.chk_shift || cmd.chk_red || cmd.chk_goto;
		pbase = $signed(tdat[lrptd_pkg::TS_SB]);
		pkey  = la_q[SW-1:0];
		if (cmd.chk_red) begin
			pbase = $signed(tdat[lrptd_pkg::TS_RB]);
		end else if (cmd.chk_goto) begin
			pbase = $signed(tdat[lrptd_pkg::TS_GB]);
			pkey  = st_q;
		end
		pn    = XW'(pbase) + XW'({1'b0, pkey});
		pre_d = (pbase != '0) && !pn[XW-1] && (pn <= XW'({1'b0, plimit_q}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q <= 1'b0;
		end else if (chk) begin
			pre_q <= pre_d;
		end
	end

	always_ff @(posedge clk) begin
		if (chk) begin
			key_q <= pkey;
		end
	end

	// stack arithmetic
	always_comb begin
		sp_inc = sp_q + 1'b1;
		len    = $signed(tdat[lrptd_pkg::TS_RL]);
		len_ge = ({1'b0, len} >= 17'(sp_q));
		sp_pop = sp_q;
		if (!len[DW-1] && (len != '0)) begin
			sp_pop = len_ge ? '0 : (sp_q - len[SPW-1:0]);
		end
		case (cmd.push_sel)
			lrptd_pkg::PUSH_PA:    push_val = tdat[lrptd_pkg::TS_PA][SW-1:0];
			lrptd_pkg::PUSH_DG:    push_val = tdat[lrptd_pkg::TS_DG][SW-1:0];
			lrptd_pkg::PUSH_FINAL: push_val = final_q;
			default:               push_val = final_q;
		endcase
		stk_we    = cmd.start || cmd.push;
		stk_waddr = cmd.start ? '0 : sp_inc;
		stk_wdata = cmd.start ? '0 : push_val;
	end

	lrptd_ram #(.W(SW), .DEPTH(STACK_DEPTH)) u_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.re   (cmd.pop),
		.raddr(sp_pop),
		.rdata(stk_rdata)
	);

	// top of stack, stack pointer, lookahead, rule
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			st_q <= '0;
			la_q <= '1;
		end else begin
			if (cmd.start) begin
				sp_q <= '0;
				st_q <= '0;
				la_q <= LW'({1'b0, entry_token});
			end
			if (cmd.xlat_ld) begin
				la_q <= LW'({1'b0, tdat[lrptd_pkg::TS_TT][SW-1:0]});
			end
			if (cmd.clr_la) begin
				la_q <= '1;
			end
			if (cmd.push) begin
				sp_q <= sp_inc;
				st_q <= push_val;
			end
			if (cmd.pop) begin
				sp_q <= sp_pop;
			end
			if (cmd.st_ld) begin
				st_q <= stk_rdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rule_dr) begin
			rule_q <= $signed(tdat[lrptd_pkg::TS_DR]);
		end else if (cmd.rule_pa) begin
			rule_q <= $signed(tdat[lrptd_pkg::TS_PA]);
		end
	end

	// result holding stage and output register
	assign out_free = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.emit) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					out_v_q <= 1'b1;
				end else if (out_ready) begin
					out_v_q <= 1'b0;
				end
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.emit && pend_v_q) || cmd.flush) begin
			event_kind     <= pend_kind_q;
			rule_number    <= pend_rule_q;
			new_state      <= pend_st_q;
			lookahead_code <= pend_la_q;
			last_event     <= cmd.flush;
		end
		if (cmd.emit) begin
			pend_kind_q <= cmd.emit_kind;
			pend_rule_q <= cmd.emit_rule ? rule_q[9:0] : '0;
			pend_st_q   <= st_q;
			pend_la_q   <= la_q;
		end
	end

	assign out_valid = out_v_q;

	// status
	always_comb begin
		sts.dr_zero   = (tdat[lrptd_pkg::TS_DR] == '0);
		sts.la_neg    = la_q[LW-1];
		sts.la_zero   = (la_q == '0);
		sts.xlat_zero = (tdat[lrptd_pkg::TS_TT][SW-1:0] == '0);
		sts.hit       = pre_q && ($signed(tdat[lrptd_pkg::TS_PC]) == DW'({1'b0, key_q}));
		sts.full      = (sp_q == SPW'(STACK_DEPTH - 1));
		sts.st_zero   = (st_q == '0);
		sts.lhs_zero  = (tdat[lrptd_pkg::TS_LH] == '0);
		sts.pend_v    = pend_v_q;
		sts.out_free  = out_free;
	end

	// a push never happens on a full stack
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !sts.full) else $error("push on full stack");

	// the holding stage only moves out when the output register is free
	a_move_free: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.emit && pend_v_q) || cmd.flush) |-> out_free)
		else $error("result overwritten");

endmodule
`default_nettype wire

>>> rtl/lrptd_ctrl.sv
// lrptd_ctrl: controller state machine of the lr parse engine; sequences table reads,
// stack operations and event emission; uses lrptd_pkg
`default_nettype none
module lrptd_ctrl #(
	parameter int STEP_LIMIT = lrptd_pkg::DEF_STEP_LIMIT
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [1:0]      opcode,
	input  wire lrptd_pkg::sts_t sts,
	output lrptd_pkg::cmd_t      cmd
);

	localparam int CW = $clog2(STEP_LIMIT + 1);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_XLAT  = 5'd1;
	localparam logic [4:0] S_DEF   = 5'd2;
	localparam logic [4:0] S_DEC   = 5'd3;
	localparam logic [4:0] S_SCHK  = 5'd4;
	localparam logic [4:0] S_RCHK  = 5'd5;
	localparam logic [4:0] S_RED   = 5'd6;
	localparam logic [4:0] S_POP   = 5'd7;
	localparam logic [4:0] S_GO0   = 5'd8;
	localparam logic [4:0] S_GO1   = 5'd9;
	localparam logic [4:0] S_GO2   = 5'd10;
	localparam logic [4:0] S_GO3   = 5'd11;
	localparam logic [4:0] S_ESH   = 5'd12;
	localparam logic [4:0] S_ERED  = 5'd13;
	localparam logic [4:0] S_EREDF = 5'd14;
	localparam logic [4:0] S_FAIL  = 5'd15;
	localparam logic [4:0] S_FLUSH = 5'd16;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_WAIT  = 2'd1;
	localparam logic [1:0] PH_FINAL = 2'd2;

	logic [4:0]  state_q, state_d;
	logic [1:0]  phase_q, phase_d;
	logic [lrptd_pkg::KIND_W-1:0] kind_q, kind_d;
	logic [CW-1:0] cnt_q;
	logic        lim, emit_ok, acc;

	assign lim     = (cnt_q >= CW'(STEP_LIMIT - 1));
	assign emit_ok = !sts.pend_v || sts.out_free;
	assign in_ready = (state_q == S_IDLE);
	assign acc     = in_valid && in_ready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		kind_d  = kind_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (opcode)
						lrptd_pkg::OP_LOAD: cmd.load = 1'b1;
						lrptd_pkg::OP_START: begin
							cmd.start = 1'b1;
							phase_d   = PH_WAIT;
							state_d   = S_DEF;
						end
						lrptd_pkg::OP_TOKEN: begin
							if (phase_q != PH_IDLE) begin
								cmd.xlat_rd = 1'b1;
								state_d     = S_XLAT;
							end
						end
						default: ;
					endcase
				end
			end
			S_XLAT: begin
				cmd.xlat_ld = 1'b1;
				if (phase_q == PH_FINAL && sts.xlat_zero) begin
					kind_d  = lrptd_pkg::EV_ACCEPT;
					state_d = S_FAIL;
				end else begin
					state_d = S_DEF;
				end
			end
			S_DEF: begin
				cmd.rd_state = 1'b1;
				state_d      = S_DEC;
			end
			S_DEC: begin
				if (!sts.dr_zero) begin
					cmd.rule_dr = 1'b1;
					state_d     = S_RED;
				end else if (sts.la_neg) begin
					phase_d = PH_WAIT;
					state_d = S_FLUSH;
				end else begin
					cmd.chk_shift = 1'b1;
					state_d       = S_SCHK;
				end
			end
			S_SCHK: begin
				if (sts.hit) begin
					if (lim) begin
						kind_d  = lrptd_pkg::EV_LIMIT;
						state_d = S_FAIL;
					end else if (sts.full) begin
						kind_d  = lrptd_pkg::EV_OVERFLOW;
						state_d = S_FAIL;
					end else begin
						cmd.push     = 1'b1;
						cmd.push_sel = lrptd_pkg::PUSH_PA;
						cmd.clr_la   = 1'b1;
						state_d      = S_ESH;
					end
				end else begin
					cmd.chk_red = 1'b1;
					state_d     = S_RCHK;
				end
			end
			S_RCHK: begin
				if (sts.hit) begin
					cmd.rule_pa = 1'b1;
					state_d     = S_RED;
				end else begin
					kind_d  = lrptd_pkg::EV_SYNTAX;
					state_d = S_FAIL;
				end
			end
			S_RED: begin
				if (lim) begin
					kind_d  = lrptd_pkg::EV_LIMIT;
					state_d = S_FAIL;
				end else begin
					cmd.rd_rule = 1'b1;
					state_d     = S_POP;
				end
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = S_GO0;
			end
			S_GO0: begin
				cmd.st_ld = 1'b1;
				state_d   = S_GO1;
			end
			S_GO1: begin
				if (sts.st_zero && sts.lhs_zero) begin
					if (sts.full) begin
						kind_d  = lrptd_pkg::EV_OVERFLOW;
						state_d = S_FAIL;
					end else begin
						cmd.push     = 1'b1;
						cmd.push_sel = lrptd_pkg::PUSH_FINAL;
						state_d      = S_EREDF;
					end
				end else begin
					cmd.rd_goto = 1'b1;
					state_d     = S_GO2;
				end
			end
			S_GO2: begin
				cmd.chk_goto = 1'b1;
				state_d      = S_GO3;
			end
			S_GO3: begin
				if (sts.full) begin
					kind_d  = lrptd_pkg::EV_OVERFLOW;
					state_d = S_FAIL;
				end else begin
					cmd.push     = 1'b1;
					cmd.push_sel = sts.hit ? lrptd_pkg::PUSH_PA : lrptd_pkg::PUSH_DG;
					state_d      = S_ERED;
				end
			end
			S_ESH: begin
				if (emit_ok) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = lrptd_pkg::EV_SHIFT;
					state_d       = S_DEF;
				end
			end
			S_ERED: begin
				if (emit_ok) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = lrptd_pkg::EV_REDUCE;
					cmd.emit_rule = 1'b1;
					state_d       = S_DEF;
				end
			end
			S_EREDF: begin
				if (emit_ok) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = lrptd_pkg::EV_REDUCE;
					cmd.emit_rule = 1'b1;
					if (sts.la_neg) begin
						phase_d = PH_FINAL;
						state_d = S_FLUSH;
					end else if (sts.la_zero) begin
						kind_d  = lrptd_pkg::EV_ACCEPT;
						state_d = S_FAIL;
					end else begin
						state_d = S_DEF;
					end
				end
			end
			S_FAIL: begin
				if (emit_ok) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = kind_q;
					phase_d       = PH_IDLE;
					state_d       = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (!sts.pend_v) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state, phase and event count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_IDLE;
			kind_q  <= lrptd_pkg::EV_SHIFT;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			kind_q  <= kind_d;
			if (acc) begin
				cnt_q <= '0;
			end else if (cmd.emit) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// events per item stay within the step limit
	a_cnt_lim: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STEP_LIMIT)) else $error("event count beyond limit");

	// no result left held while waiting for the next item
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !sts.pend_v) else $error("held result at idle");

	// an emit only when the holding stage can take it
	a_emit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> emit_ok) else $error("emit while blocked");

endmodule
`default_nettype wire

>>> rtl/lr_parse_table_driver_core.sv
// lr_parse_table_driver_core: top level of the table-driven lr parse engine
// instantiates lrptd_ctrl and lrptd_dp; uses lrptd_pkg
//
// Usage: items enter on the in channel (in_valid/in_ready). A load item writes one
// word of one of ten parse tables and gives no result; load tables before parsing.
// A start item resets the state stack and takes entry_token as lookahead; a token
// item translates token_tag and resumes the parse. Each shift, reduce or terminal
// event leaves as one item on the out channel (out_valid/out_ready); last_event
// marks the final one caused by an input item. Registers packed_limit (index 0)
// and final_state (index 1) are written through cfg_we/cfg_index/cfg_data.
// Timing: one item at a time. Each event walks part of a chain of registered table
// reads (default, packed, rule, stack, goto) in the controller. One event is held
// back so the last one can be flagged; the final result moves from the holding
// stage to the output register as the engine returns to idle.
// If the receiver stalls, the engine halts at its next event until the output
// register frees. Reset empties the stack, clears the lookahead to none and
// leaves the engine idle; table contents are undefined until loaded.
`default_nettype none
module lr_parse_table_driver_core #(
	parameter int TABLE_WORDS = lrptd_pkg::DEF_TABLE_WORDS,
	parameter int STACK_DEPTH = lrptd_pkg::DEF_STACK_DEPTH,
	parameter int STEP_LIMIT  = lrptd_pkg::DEF_STEP_LIMIT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic                                cfg_index,
	input  wire logic [lrptd_pkg::ST_W-1:0]          cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [1:0]                          opcode,
	input  wire logic [lrptd_pkg::TSEL_W-1:0]        table_select,
	input  wire logic [9:0]                          entry_index,
	input  wire logic signed [lrptd_pkg::DATA_W-1:0] entry_value,
	input  wire logic [9:0]                          entry_token,
	input  wire logic [9:0]                          token_tag,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [lrptd_pkg::KIND_W-1:0]             event_kind,
	output logic [9:0]                               rule_number,
	output logic [lrptd_pkg::ST_W-1:0]               new_state,
	output logic signed [lrptd_pkg::LA_W-1:0]        lookahead_code,
	output logic                                     last_event
);

	lrptd_pkg::cmd_t cmd;
	lrptd_pkg::sts_t sts;

	// sequencer
	lrptd_ctrl #(.STEP_LIMIT(STEP_LIMIT)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode  (opcode),
		.sts     (sts),
		.cmd     (cmd)
	);

	// tables, stack and result registers
	lrptd_dp #(.TABLE_WORDS(TABLE_WORDS), .STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.table_select  (table_select),
		.entry_index   (entry_index),
		.entry_value   (entry_value),
		.entry_token   (entry_token),
		.token_tag     (token_tag),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_kind    (event_kind),
		.rule_number   (rule_number),
		.new_state     (new_state),
		.lookahead_code(lookahead_code),
		.last_event    (last_event)
	);

endmodule
`default_nettype wire
